>>> sv/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared constants, types, and the division step and saturation functions of the ray/box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int TOL_W     = 16;
   localparam int NUM_W     = COORD_W + 1 + FRAC_BITS;
   localparam int QUO_W     = COORD_W;
   localparam int NUM_AXES  = 3;
   localparam int NUM_DIVS  = 2 * NUM_AXES;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LO_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LO_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LO_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HI_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HI_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HI_Z = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE = 3'd6;

   localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] FP_ONE    = COORD_W'(1) << FRAC_BITS;
   localparam logic signed [COORD_W-1:0] FP_ZERO   = '0;

   // Operands of one slab distance before the overflow check.
   typedef struct packed {
      logic [NUM_W-1:0]   num;
      logic [COORD_W-1:0] den;
      logic               neg;
   } div_init_type;

   // Running state of one restoring division.
   typedef struct packed {
      logic [COORD_W-1:0] rem;
      logic [QUO_W-1:0]   nq;
      logic [COORD_W-1:0] den;
      logic               neg;
      logic               over;
   } axis_div_type;

   typedef struct packed {
      div_init_type [NUM_DIVS-1:0] div;
      logic [NUM_AXES-1:0]         divides;
      logic                        miss;
   } init_stage_type;

   typedef struct packed {
      axis_div_type [NUM_DIVS-1:0] div;
      logic [NUM_AXES-1:0]         divides;
      logic                        miss;
   } div_stage_type;

   function automatic axis_div_type div_step(axis_div_type d);
      logic [COORD_W:0] trial;
      logic [COORD_W:0] diff;
      axis_div_type     s;
      trial = {d.rem, d.nq[QUO_W-1]};
      diff  = trial - {1'b0, d.den};
      s     = d;
      if (!diff[COORD_W]) begin
         s.rem = diff[COORD_W-1:0];
         s.nq  = {d.nq[QUO_W-2:0], 1'b1};
      end else begin
         s.rem = trial[COORD_W-1:0];
         s.nq  = {d.nq[QUO_W-2:0], 1'b0};
      end
      return s;
   endfunction

   // Signs the quotient and saturates it to the coordinate range.
   function automatic logic signed [COORD_W-1:0] sat_quo(axis_div_type d);
      logic signed [COORD_W-1:0] r;
      if (d.neg) begin
         if (d.over || (d.nq[QUO_W-1] && (d.nq[QUO_W-2:0] != '0))) begin
            r = COORD_MIN;
         end else begin
            r = COORD_W'(-d.nq);
         end
      end else begin
         if (d.over || d.nq[QUO_W-1]) begin
            r = COORD_MAX;
         end else begin
            r = d.nq;
         end
      end
      return r;
   endfunction

endpackage

>>> sv/ray_box_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_core
// Slab test of a ray against an axis-aligned box in signed Q16.16.
// ----------------------------------------------------------------------------
// Registers in order: in_ff, s1_ff, pipe_ff[0..32], sat_ff, near_ff/far_ff, entry_ff/exit_ff, out_ff.
// Throughput: one ray per cycle while the output is not stalled; the 32 restoring-division stages (one
// quotient bit each, six dividers side by side) set the pipeline depth.
// The whole pipeline holds while a finished result waits on rsp_tready.
// Reset: synchronous, active high; clears all valid bits and loads the box
// registers with the unit cube and the tolerance with one LSB.
module ray_box_slab_intersect_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic [6*rbsi_pkg::COORD_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // hit, entry_distance, exit_distance
   output logic [2*rbsi_pkg::COORD_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rbsi_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rbsi_pkg::COORD_W-1:0]     csr_data
);
   import rbsi_pkg::*;

   logic signed [COORD_W-1:0] box_lo_ff [NUM_AXES];
   logic signed [COORD_W-1:0] box_hi_ff [NUM_AXES];
   logic [TOL_W-1:0]          tol_ff;

   logic                      adv;

   logic                      in_vld_ff;
   logic [6*COORD_W-1:0]      in_ff;
   logic                      s1_vld_ff;
   init_stage_type            s1_ff, s1_in;
   logic                      pipe_vld_ff [QUO_W+1];
   div_stage_type             pipe_ff [QUO_W+1];
   div_stage_type             pipe0_in;

   logic                      sat_vld_ff;
   logic signed [COORD_W-1:0] sat_ff [NUM_DIVS];
   logic [NUM_AXES-1:0]       sat_div_ff;
   logic                      sat_miss_ff;

   logic                      ord_vld_ff;
   logic signed [COORD_W-1:0] near_ff [NUM_AXES], near_in [NUM_AXES];
   logic signed [COORD_W-1:0] far_ff [NUM_AXES], far_in [NUM_AXES];
   logic                      ord_miss_ff;

   logic                      red_vld_ff;
   logic signed [COORD_W-1:0] entry_ff, entry_in, exit_ff, exit_in;
   logic                      red_miss_ff;

   logic                      out_vld_ff;
   logic [2*COORD_W-1:0]      out_ff, out_in;

   // The pipeline moves unless a result waits in the output register with rsp_tready low.
   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            box_lo_ff[i] <= FP_ZERO;
            box_hi_ff[i] <= FP_ONE;
         end
         tol_ff <= TOL_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BOX_LO_X:  box_lo_ff[0] <= csr_data;
            CSR_BOX_LO_Y:  box_lo_ff[1] <= csr_data;
            CSR_BOX_LO_Z:  box_lo_ff[2] <= csr_data;
            CSR_BOX_HI_X:  box_hi_ff[0] <= csr_data;
            CSR_BOX_HI_Y:  box_hi_ff[1] <= csr_data;
            CSR_BOX_HI_Z:  box_hi_ff[2] <= csr_data;
            CSR_TOLERANCE: tol_ff       <= csr_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   // Slab operands: |corner - origin| scaled, |direction|, quotient sign.
   always_comb begin
      logic signed [COORD_W-1:0] p, d;
      logic signed [COORD_W:0]   diff;
      logic [COORD_W:0]          mag;
      logic [COORD_W-1:0]        dmag;
      s1_in = '0;
      for (int i = 0; i < NUM_AXES; i++) begin
         p    = in_ff[i*COORD_W +: COORD_W];
         d    = in_ff[(NUM_AXES+i)*COORD_W +: COORD_W];
         dmag = d[COORD_W-1] ? COORD_W'(-d) : d;
         s1_in.divides[i] = dmag > {{(COORD_W-TOL_W){1'b0}}, tol_ff};
         if (!s1_in.divides[i] && ((box_lo_ff[i] > p) || (p > box_hi_ff[i]))) begin
            s1_in.miss = 1'b1;
         end
         for (int c = 0; c < 2; c++) begin
            diff = (c == 0) ? ({box_lo_ff[i][COORD_W-1], box_lo_ff[i]} - {p[COORD_W-1], p})
                            : ({box_hi_ff[i][COORD_W-1], box_hi_ff[i]} - {p[COORD_W-1], p});
            mag  = diff[COORD_W] ? (COORD_W+1)'(-diff) : diff;
            s1_in.div[2*i+c].num = {mag, {FRAC_BITS{1'b0}}};
            s1_in.div[2*i+c].den = dmag;
            s1_in.div[2*i+c].neg = diff[COORD_W] ^ d[COORD_W-1];
         end
      end
   end

   // Quotients of 2^32 or more are flagged here; all still run the 32 division steps.
   always_comb begin
      pipe0_in.divides = s1_ff.divides;
      pipe0_in.miss    = s1_ff.miss;
      for (int k = 0; k < NUM_DIVS; k++) begin
         pipe0_in.div[k].rem  = COORD_W'(s1_ff.div[k].num[NUM_W-1:QUO_W]);
         pipe0_in.div[k].nq   = s1_ff.div[k].num[QUO_W-1:0];
         pipe0_in.div[k].den  = s1_ff.div[k].den;
         pipe0_in.div[k].neg  = s1_ff.div[k].neg;
         pipe0_in.div[k].over = COORD_W'(s1_ff.div[k].num[NUM_W-1:QUO_W]) >= s1_ff.div[k].den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         s1_vld_ff      <= 1'b0;
         pipe_vld_ff[0] <= 1'b0;
      end else if (adv) begin
         in_vld_ff      <= req_tvalid;
         s1_vld_ff      <= in_vld_ff;
         pipe_vld_ff[0] <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_ff      <= req_tdata;
         s1_ff      <= s1_in;
         pipe_ff[0] <= pipe0_in;
      end
   end

   for (genvar g = 0; g < QUO_W; g++) begin : g_div
      div_stage_type step_in;
      always_comb begin
         step_in = pipe_ff[g];
         for (int k = 0; k < NUM_DIVS; k++) begin
            step_in.div[k] = div_step(pipe_ff[g].div[k]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            pipe_vld_ff[g+1] <= 1'b0;
         end else if (adv) begin
            pipe_vld_ff[g+1] <= pipe_vld_ff[g];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            pipe_ff[g+1] <= step_in;
         end
      end
   end

   // Near and far per axis; an axis without division leaves the range open.
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (!sat_div_ff[i]) begin
            near_in[i] = COORD_MIN;
            far_in[i]  = COORD_MAX;
         end else if (sat_ff[2*i] > sat_ff[2*i+1]) begin
            near_in[i] = sat_ff[2*i+1];
            far_in[i]  = sat_ff[2*i];
         end else begin
            near_in[i] = sat_ff[2*i];
            far_in[i]  = sat_ff[2*i+1];
         end
      end
   end

   always_comb begin
      entry_in = near_ff[0];
      exit_in  = far_ff[0];
      for (int i = 1; i < NUM_AXES; i++) begin
         if (near_ff[i] > entry_in) entry_in = near_ff[i];
         if (far_ff[i] < exit_in)   exit_in  = far_ff[i];
      end
   end

   always_comb begin
      logic signed [COORD_W-1:0] ent;
      logic signed [COORD_W:0]   span;
      logic                      miss;
      ent  = entry_ff[COORD_W-1] ? FP_ZERO : entry_ff;
      span = {exit_ff[COORD_W-1], exit_ff} - {ent[COORD_W-1], ent};
      miss = red_miss_ff || span[COORD_W]
             || (span < (COORD_W+1)'({1'b0, tol_ff}));
      if (miss) begin
         out_in = '0;
      end else begin
         out_in = {exit_ff, ent[COORD_W-2:0], 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_vld_ff <= 1'b0;
         ord_vld_ff <= 1'b0;
         red_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         sat_vld_ff <= pipe_vld_ff[QUO_W];
         ord_vld_ff <= sat_vld_ff;
         red_vld_ff <= ord_vld_ff;
         out_vld_ff <= red_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_DIVS; k++) begin
            sat_ff[k] <= sat_quo(pipe_ff[QUO_W].div[k]);
         end
         sat_div_ff  <= pipe_ff[QUO_W].divides;
         sat_miss_ff <= pipe_ff[QUO_W].miss;
         for (int i = 0; i < NUM_AXES; i++) begin
            near_ff[i] <= near_in[i];
            far_ff[i]  <= far_in[i];
         end
         ord_miss_ff <= sat_miss_ff;
         entry_ff    <= entry_in;
         exit_ff     <= exit_in;
         red_miss_ff <= ord_miss_ff;
         out_ff      <= out_in;
      end
   end

endmodule

>>> sv/rbsi_checker.sv
// ----------------------------------------------------------------------------
// rbsi_checker
// Port-level checks of the ray/box slab test core.
// ----------------------------------------------------------------------------
module rbsi_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [191:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        csr_valid,
   input logic        csr_ready,
   input logic [2:0]  csr_index,
   input logic [31:0] csr_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[63:1] == 63'd0)
      else $error("miss with non-zero distances");

   a_hit_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |->
         rsp_tdata[63] == 1'b0 && rsp_tdata[62:32] >= rsp_tdata[31:1])
      else $error("hit with exit before entry");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input held off without an output stall");

endmodule

bind ray_box_slab_intersect_core rbsi_checker u_rbsi_checker (.*);
